### hdl/seven_segment_serial_writer_top_assert.svh
// Assertion macros for the seven-segment serial writer; the back part uses them.
// Each macro expects clk and arst_n to be visible at the place of use.
`ifndef SEVEN_SEGMENT_SERIAL_WRITER_TOP_ASSERT_SVH
`define SEVEN_SEGMENT_SERIAL_WRITER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SSWR_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SSWR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/sswr_pkg.sv
// Types, constants and the segment font for the seven-segment serial writer.
// No dependencies; every other file but the assertion macro header imports this package.
package sswr_pkg;

	localparam int FRAME_W = 16;

	// Operation codes of an input item.
	localparam logic OP_SHOW   = 1'b0;
	localparam logic OP_BRIGHT = 1'b1;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_MODE_CMD  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MODE_FLAG = 2'd1;

	localparam logic [7:0] MODE_CMD_RESET  = 8'h48;
	localparam logic [7:0] MODE_FLAG_RESET = 8'h01;
	localparam logic [7:0] DIGIT_ADDR_BASE = 8'h68;

	// Phase boundaries within one 46-phase frame.
	localparam logic [5:0] PH_BYTE0   = 6'd4;
	localparam logic [5:0] PH_ACK0    = 6'd20;
	localparam logic [5:0] PH_BYTE1   = 6'd23;
	localparam logic [5:0] PH_ACK1    = 6'd39;
	localparam logic [5:0] PH_STOP    = 6'd42;
	localparam logic [5:0] PH_LAST    = 6'd45;

	typedef struct packed {
		logic       operation;
		logic [1:0] digit_index;
		logic [6:0] symbol_code;
		logic [2:0] brightness_level;
	} cmd_t;

	typedef struct packed {
		logic clock_level;
		logic data_level;
		logic data_drive;
		logic sample_ack;
		logic last_phase;
	} phase_t;

	typedef logic [FRAME_W-1:0] frame_t;

	// Segment code of an ASCII symbol; unmapped symbols are blank.
	function automatic logic [7:0] glyph(input logic [6:0] s);
		logic [7:0] g;
		case (s)
			7'h30: g = 8'h3F;
			7'h31: g = 8'h06;
			7'h32: g = 8'h5B;
			7'h33: g = 8'h4F;
			7'h34: g = 8'h66;
			7'h35: g = 8'h6D;
			7'h36: g = 8'h7D;
			7'h37: g = 8'h07;
			7'h38: g = 8'h7F;
			7'h39: g = 8'h6F;
			7'h41: g = 8'h77; // A
			7'h62: g = 8'h7C; // b
			7'h43: g = 8'h39; // C
			7'h63: g = 8'h58; // c
			7'h64: g = 8'h5E; // d
			7'h45: g = 8'h79; // E
			7'h46: g = 8'h71; // F
			7'h67: g = 8'h6F; // g
			7'h47: g = 8'h3D; // G
			7'h48: g = 8'h76; // H
			7'h68: g = 8'h74; // h
			7'h69: g = 8'h05; // i
			7'h49: g = 8'h06; // I
			7'h6A: g = 8'h0D; // j
			7'h4C: g = 8'h38; // L
			7'h6C: g = 8'h30; // l
			7'h6E: g = 8'h54; // n
			7'h4E: g = 8'h37; // N
			7'h4F: g = 8'h3F; // O
			7'h6F: g = 8'h5C; // o
			7'h50: g = 8'h73; // P
			7'h71: g = 8'h67; // q
			7'h72: g = 8'h50; // r
			7'h53: g = 8'h6D; // S
			7'h74: g = 8'h78; // t
			7'h55: g = 8'h3E; // U
			7'h75: g = 8'h1C; // u
			7'h79: g = 8'h6E; // y
			7'h3D: g = 8'h48; // =
			7'h5F: g = 8'h08; // _
			7'h2D: g = 8'h40; // -
			7'h2A: g = 8'h63; // *
			default: g = 8'h00;
		endcase
		return g;
	endfunction

endpackage

### hdl/sswr_front.sv
// Front part: takes command items, holds the mode registers and builds the frame bytes.
// Depends on sswr_pkg.
module sswr_front import sswr_pkg::*; #(
	parameter int DIGIT_COUNT = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  cmd_t                 cmd,
	input  logic                 q_full,
	output logic                 full,
	output logic                 q_wr,
	output frame_t               q_wdata,
	input  logic                 cfg_valid,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data
);

	logic [7:0] mode_cmd_q;
	logic [7:0] mode_flag_q;
	logic       accept;
	logic       digit_ok;
	logic [7:0] addr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_cmd_q  <= MODE_CMD_RESET;
			mode_flag_q <= MODE_FLAG_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_MODE_CMD:  mode_cmd_q  <= cfg_data;
				CFG_MODE_FLAG: mode_flag_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign full     = q_full;
	assign accept   = push && !q_full;
	assign digit_ok = {1'b0, cmd.digit_index} < 3'(DIGIT_COUNT);
	assign addr     = DIGIT_ADDR_BASE + {5'd0, cmd.digit_index, 1'b0};

	// A show item aimed past the last digit is taken and dropped.
	assign q_wr = accept && (cmd.operation == OP_BRIGHT || digit_ok);

	always_comb begin
		if (cmd.operation == OP_BRIGHT) begin
			q_wdata = {mode_cmd_q, mode_flag_q | {5'd0, cmd.brightness_level}};
		end else begin
			q_wdata = {addr, glyph(cmd.symbol_code)};
		end
	end

endmodule

### hdl/sswr_fifo.sv
// Two-entry frame queue between the front and back parts.
// Depends on sswr_pkg.
module sswr_fifo import sswr_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   wr,
	input  frame_t wdata,
	input  logic   rd,
	output frame_t rdata,
	output logic   full,
	output logic   empty
);

	frame_t     mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (wr) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (rd) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (wr && !rd) begin
				count_q <= count_q + 2'd1;
			end else if (rd && !wr) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	assign rdata = mem_q[rd_ptr_q];
	assign full  = count_q == 2'd2;
	assign empty = count_q == 2'd0;

endmodule

### hdl/sswr_back.sv
// Back part: walks one frame through its 46 wire phases into the result register.
// Depends on sswr_pkg and the assertion macro header.
module sswr_back import sswr_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   q_empty,
	input  frame_t q_rdata,
	output logic   q_rd,
	output logic   empty,
	input  logic   pop,
	output phase_t result
);

	logic       busy_q;
	logic [5:0] phase_q;
	frame_t     shift_q;
	phase_t     out_q;
	logic       out_valid_q;
	phase_t     cur;
	logic       advance;
	logic       is_last;
	logic       load;

	always_comb begin
		cur = '0;
		if (phase_q < PH_BYTE0) begin
			cur.clock_level = phase_q != 6'd3;
			cur.data_level  = phase_q < 6'd2;
			cur.data_drive  = 1'b1;
		end else if (phase_q < PH_ACK0) begin
			cur.clock_level = phase_q[0];
			cur.data_level  = shift_q[FRAME_W-1];
			cur.data_drive  = 1'b1;
		end else if (phase_q < PH_BYTE1) begin
			cur.clock_level = phase_q != PH_ACK0;
			cur.sample_ack  = phase_q == PH_ACK0 + 6'd1;
		end else if (phase_q < PH_ACK1) begin
			cur.clock_level = ~phase_q[0];
			cur.data_level  = shift_q[FRAME_W-1];
			cur.data_drive  = 1'b1;
		end else if (phase_q < PH_STOP) begin
			cur.clock_level = phase_q != PH_ACK1;
			cur.sample_ack  = phase_q == PH_ACK1 + 6'd1;
		end else begin
			cur.clock_level = phase_q >= PH_STOP + 6'd2;
			cur.data_level  = phase_q == PH_LAST;
			cur.data_drive  = 1'b1;
			cur.last_phase  = phase_q == PH_LAST;
		end
	end

	assign advance = busy_q && (!out_valid_q || pop);
	assign is_last = phase_q == PH_LAST;
	// The next frame is taken on the last phase of the current one, so frames run back to back.
	assign load    = !q_empty && (!busy_q || (advance && is_last));
	assign q_rd    = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			phase_q     <= 6'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				busy_q  <= 1'b1;
				phase_q <= 6'd0;
			end else if (advance) begin
				busy_q  <= !is_last;
				phase_q <= is_last ? 6'd0 : phase_q + 6'd1;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: the shift moves on after each clock-high data phase.
	always_ff @(posedge clk) begin
		if (load) begin
			shift_q <= q_rdata;
		end else if (advance && cur.data_drive && cur.clock_level &&
				phase_q >= PH_BYTE0 && phase_q < PH_STOP) begin
			shift_q <= shift_q << 1;
		end
		if (advance) begin
			out_q <= cur;
		end
	end

	assign empty  = !out_valid_q;
	assign result = out_q;

`include "seven_segment_serial_writer_top_assert.svh"

	`SSWR_ASSERT_SAME(a_phase_range, busy_q, phase_q <= PH_LAST, "phase index past frame end")
	`SSWR_ASSERT_SAME(a_idle_phase, !busy_q, phase_q == 6'd0, "phase index not cleared when idle")
	`SSWR_ASSERT_SAME(a_ack_released, out_valid_q && out_q.sample_ack,
		!out_q.data_drive && out_q.clock_level, "acknowledge sampled with data driven")
	`SSWR_ASSERT_SAME(a_stop_level, out_valid_q && out_q.last_phase,
		out_q.clock_level && out_q.data_level && out_q.data_drive, "bad stop level")
	`SSWR_ASSERT_NEXT(a_frame_done, advance && is_last && !load, !busy_q, "frame did not end")

endmodule

### hdl/seven_segment_serial_writer_top.sv
// An item's frame goes to the frame queue, then to the back part's shift register, and the
// phase sequencer walks its 46 phases into the result register, one phase per cycle while
// the reader pops; a two-frame queue lets the front take items meanwhile.
// A show item for a digit past DIGIT_COUNT is taken and gives no results.
// Reset (arst_n low, asynchronous) empties queue and result, restores mode registers.
module seven_segment_serial_writer_top import sswr_pkg::*; #(
	parameter int DIGIT_COUNT = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  cmd_t                 cmd,
	output logic                 empty,
	input  logic                 pop,
	output phase_t               result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data
);

	logic   q_wr;
	logic   q_rd;
	logic   q_full;
	logic   q_empty;
	frame_t q_wdata;
	frame_t q_rdata;

	assign cfg_ready = 1'b1;

	sswr_front #(
		.DIGIT_COUNT(DIGIT_COUNT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.cmd       (cmd),
		.q_full    (q_full),
		.full      (full),
		.q_wr      (q_wr),
		.q_wdata   (q_wdata),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	sswr_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.wdata  (q_wdata),
		.rd     (q_rd),
		.rdata  (q_rdata),
		.full   (q_full),
		.empty  (q_empty)
	);

	sswr_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_rdata (q_rdata),
		.q_rd    (q_rd),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

endmodule

### dv/testbench.sv
`timescale 1ns / 100ps
// Testbench for seven_segment_serial_writer_top: sends show and brightness items,
// predicts every 46-phase wire frame and checks each phase popped from the block.
// Depends on sswr_pkg and the top-level RTL only.
module testbench;
	import sswr_pkg::*;

	localparam int DIGITS = 4;
	localparam int SETTLE_CYCLES = 6;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	logic                 clk;
	logic                 arst_n;
	logic                 push;
	logic                 full;
	cmd_t                 cmd;
	logic                 empty;
	logic                 pop;
	phase_t               result;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [7:0]           cfg_data;

	// Predictor state.
	logic [7:0] mode_cmd_reg;
	logic [7:0] mode_flag_reg;
	logic [2:0] held_brightness;
	logic [7:0] segment_font [128];
	phase_t     expected_phases [$];

	int  mismatch_count;
	int  quiet_cycles;
	int  stall_left;
	bit  sender_gaps;
	bit  reader_stalls;

	seven_segment_serial_writer_top #(.DIGIT_COUNT(DIGITS)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.cmd      (cmd),
		.empty    (empty),
		.pop      (pop),
		.result   (result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic void load_font();
		logic [7:0] numerals [10] = '{8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66,
			8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F};
		foreach (segment_font[i]) segment_font[i] = 8'h00;
		foreach (numerals[i]) segment_font[7'h30 + 7'(i)] = numerals[i];
		segment_font[7'h41] = 8'h77; // A
		segment_font[7'h62] = 8'h7C; // b
		segment_font[7'h43] = 8'h39; // C
		segment_font[7'h63] = 8'h58; // c
		segment_font[7'h64] = 8'h5E; // d
		segment_font[7'h45] = 8'h79; // E
		segment_font[7'h46] = 8'h71; // F
		segment_font[7'h67] = 8'h6F; // g
		segment_font[7'h47] = 8'h3D; // G
		segment_font[7'h48] = 8'h76; // H
		segment_font[7'h68] = 8'h74; // h
		segment_font[7'h69] = 8'h05; // i
		segment_font[7'h49] = 8'h06; // I
		segment_font[7'h6A] = 8'h0D; // j
		segment_font[7'h4C] = 8'h38; // L
		segment_font[7'h6C] = 8'h30; // l
		segment_font[7'h6E] = 8'h54; // n
		segment_font[7'h4E] = 8'h37; // N
		segment_font[7'h4F] = 8'h3F; // O
		segment_font[7'h6F] = 8'h5C; // o
		segment_font[7'h50] = 8'h73; // P
		segment_font[7'h71] = 8'h67; // q
		segment_font[7'h72] = 8'h50; // r
		segment_font[7'h53] = 8'h6D; // S
		segment_font[7'h74] = 8'h78; // t
		segment_font[7'h55] = 8'h3E; // U
		segment_font[7'h75] = 8'h1C; // u
		segment_font[7'h79] = 8'h6E; // y
		segment_font[7'h3D] = 8'h48; // =
		segment_font[7'h5F] = 8'h08; // _
		segment_font[7'h2D] = 8'h40; // -
		segment_font[7'h2A] = 8'h63; // *
	endfunction

	function automatic void add_phase(logic c, logic d, logic drv, logic ack, logic last);
		phase_t p;
		p.clock_level = c;
		p.data_level  = d;
		p.data_drive  = drv;
		p.sample_ack  = ack;
		p.last_phase  = last;
		expected_phases.push_back(p);
	endfunction

	// Queues the 46 wire phases that one accepted item produces.
	function automatic void predict_frame(cmd_t c);
		frame_t frame;
		logic   b;
		if (c.operation == OP_SHOW) begin
			if (c.digit_index >= DIGITS) return;
			frame = {DIGIT_ADDR_BASE + {5'd0, c.digit_index, 1'b0}, segment_font[c.symbol_code]};
		end else begin
			held_brightness = c.brightness_level;
			frame = {mode_cmd_reg, mode_flag_reg | {5'd0, held_brightness}};
		end
		add_phase(1, 1, 1, 0, 0);
		add_phase(1, 1, 1, 0, 0);
		add_phase(1, 0, 1, 0, 0);
		add_phase(0, 0, 1, 0, 0);
		for (int byte_no = 0; byte_no < 2; byte_no++) begin
			for (int i = 0; i < 8; i++) begin
				b = frame[4'(15 - byte_no * 8 - i)];
				add_phase(0, b, 1, 0, 0);
				add_phase(1, b, 1, 0, 0);
			end
			// The line is released for the acknowledge slot.
			add_phase(0, 0, 0, 0, 0);
			add_phase(1, 0, 0, 1, 0);
			add_phase(1, 0, 0, 0, 0);
		end
		add_phase(0, 0, 1, 0, 0);
		add_phase(0, 0, 1, 0, 0);
		add_phase(1, 0, 1, 0, 0);
		add_phase(1, 1, 1, 0, 1);
	endfunction

	function automatic void compare_bit(string field, logic exp, logic act);
		if (exp !== act) begin
			$error("%s: expected %0b, got %0b", field, exp, act);
			mismatch_count++;
		end
	endfunction

	// Result checker.
	always @(posedge clk) begin
		phase_t want;
		if (arst_n && pop && !empty) begin
			if (expected_phases.size() == 0) begin
				$error("phase popped with none expected: %b", result);
				mismatch_count++;
			end else begin
				want = expected_phases.pop_front();
				compare_bit("clock_level", want.clock_level, result.clock_level);
				compare_bit("data_level", want.data_level, result.data_level);
				compare_bit("data_drive", want.data_drive, result.data_drive);
				compare_bit("sample_ack", want.sample_ack, result.sample_ack);
				compare_bit("last_phase", want.last_phase, result.last_phase);
			end
		end
	end

	// Reader side: pops, with stall bursts of random length while reader_stalls is set.
	always @(posedge clk) begin
		if (stall_left != 0) begin
			pop <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (reader_stalls && $urandom_range(0, 9) == 0) begin
			pop <= 1'b0;
			stall_left <= $urandom_range(0, 18);
		end else begin
			pop <= 1'b1;
		end
	end

	// Watchdog on cycles in which nothing is accepted on any channel.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	task automatic send_command(cmd_t c);
		if (sender_gaps && $urandom_range(0, 3) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		push <= 1'b1;
		cmd  <= c;
		do @(posedge clk); while (full);
		predict_frame(c);
	endtask

	task automatic wait_until_drained();
		push <= 1'b0;
		while (expected_phases.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [7:0] value);
		wait_until_drained();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_MODE_CMD:  mode_cmd_reg  = value;
			CFG_MODE_FLAG: mode_flag_reg = value;
			default: ;
		endcase
	endtask

	function automatic cmd_t make_cmd(logic op, logic [1:0] dig, logic [6:0] sym,
			logic [2:0] bri);
		cmd_t c;
		c.operation        = op;
		c.digit_index      = dig;
		c.symbol_code      = sym;
		c.brightness_level = bri;
		return c;
	endfunction

	function automatic logic [6:0] pick_symbol();
		logic [6:0] s;
		s = 7'($urandom_range(0, 127));
		if ($urandom_range(0, 1))
			while (segment_font[s] == 8'h00) s = 7'($urandom_range(0, 127));
		return s;
	endfunction

	function automatic logic [7:0] pick_register_value();
		case ($urandom_range(0, 3))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Brightness frames with the mode registers as they come out of reset.
	task automatic test_reset_brightness();
		send_command(make_cmd(OP_BRIGHT, 2'd0, 7'h00, 3'd0));
		send_command(make_cmd(OP_BRIGHT, 2'd3, 7'h7F, 3'd7));
	endtask

	// Every digit position, font extremes and unmapped symbols.
	task automatic test_show_symbols();
		send_command(make_cmd(OP_SHOW, 2'd0, 7'h00, 3'd0));
		send_command(make_cmd(OP_SHOW, 2'd3, 7'h7F, 3'd0));
		send_command(make_cmd(OP_SHOW, 2'd1, 7'h38, 3'd0)); // 8
		send_command(make_cmd(OP_SHOW, 2'd2, 7'h30, 3'd0)); // 0
		send_command(make_cmd(OP_SHOW, 2'd0, 7'h39, 3'd0)); // 9
		send_command(make_cmd(OP_SHOW, 2'd3, 7'h41, 3'd0)); // A
		send_command(make_cmd(OP_SHOW, 2'd1, 7'h2A, 3'd0)); // *
		send_command(make_cmd(OP_SHOW, 2'd2, 7'h2D, 3'd0)); // -
		send_command(make_cmd(OP_SHOW, 2'd0, 7'h79, 3'd7)); // y
		send_command(make_cmd(OP_SHOW, 2'd1, 7'h5A, 3'd5)); // Z
	endtask

	// Mode registers at their extremes, and a write to an unused index.
	task automatic test_mode_registers();
		write_register(CFG_MODE_CMD, 8'hFF);
		write_register(CFG_MODE_FLAG, 8'hFF);
		send_command(make_cmd(OP_BRIGHT, 2'd0, 7'h00, 3'd0));
		write_register(CFG_MODE_CMD, 8'h00);
		write_register(CFG_MODE_FLAG, 8'h00);
		send_command(make_cmd(OP_BRIGHT, 2'd1, 7'h55, 3'd7));
		send_command(make_cmd(OP_BRIGHT, 2'd2, 7'h2A, 3'd0));
		write_register(CFG_UNUSED, 8'hA5);
		send_command(make_cmd(OP_BRIGHT, 2'd3, 7'h00, 3'd3));
		write_register(CFG_MODE_CMD, MODE_CMD_RESET);
		write_register(CFG_MODE_FLAG, MODE_FLAG_RESET);
		send_command(make_cmd(OP_BRIGHT, 2'd0, 7'h00, 3'd6));
	endtask

	// Random items in rounds, each under freshly written mode registers.
	task automatic test_random_traffic();
		cmd_t c;
		for (int round_no = 0; round_no < 5; round_no++) begin
			write_register(CFG_MODE_CMD, pick_register_value());
			write_register(CFG_MODE_FLAG, pick_register_value());
			if ($urandom_range(0, 2) == 0)
				write_register(CFG_UNUSED, pick_register_value());
			sender_gaps   = (round_no != 2) && (round_no != 4);
			reader_stalls = (round_no != 4);
			for (int n = 0; n < 20; n++) begin
				if (round_no == 1 && n == 10)
					wait_until_drained();
				c = make_cmd($urandom_range(0, 9) < 3 ? OP_BRIGHT : OP_SHOW,
					2'($urandom_range(0, 3)), pick_symbol(), 3'($urandom_range(0, 7)));
				send_command(c);
			end
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		push      = 1'b0;
		cmd       = '0;
		pop       = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		mismatch_count = 0;
		quiet_cycles   = 0;
		stall_left     = 0;
		sender_gaps    = 1'b1;
		reader_stalls  = 1'b1;
		mode_cmd_reg    = MODE_CMD_RESET;
		mode_flag_reg   = MODE_FLAG_RESET;
		held_brightness = 3'd0;
		load_font();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_brightness();
		test_show_symbols();
		test_mode_registers();
		test_random_traffic();

		wait_until_drained();
		if (mismatch_count == 0 && expected_phases.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
